>>> rtl/core/blsl_pkg.sv
// ----------------------------------------------------------------------------
// blsl_pkg
// Shared types and constants for the bounded sequence list engine: field
// widths, operation and status codes, and the control word of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package blsl_pkg;

   localparam int DEPTH_DEF   = 32;

   localparam int MODE_W      = 4;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 6;
   localparam int STATUS_W    = 3;
   localparam int FIDX_W      = 5;
   localparam int ECNT_W      = 6;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT   = 4'd0,
      MODE_INS_REAR    = 4'd1,
      MODE_INS_AT      = 4'd2,
      MODE_DEL_FRONT   = 4'd3,
      MODE_DEL_REAR    = 4'd4,
      MODE_DEL_AT      = 4'd5,
      MODE_DEL_KEY     = 4'd6,
      MODE_SEARCH      = 4'd7,
      MODE_INS_ORDERED = 4'd8,
      MODE_REVERSE     = 4'd9,
      MODE_READ_AT     = 4'd10
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_EMPTY      = 3'd1,
      STATUS_FULL       = 3'd2,
      STATUS_BAD_POS    = 3'd3,
      STATUS_NOT_FOUND  = 3'd4,
      STATUS_NOT_SORTED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef enum logic {
      CMP_EQUAL,
      CMP_NOT_LESS
   } cmp_type;

   typedef struct packed {
      cell_op_type         op;
      cmp_type             cmp;
      logic [VALUE_W-1:0]  word;
      logic [VALUE_W-1:0]  key;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_REVERSE
   } seq_state_type;

endpackage

`default_nettype wire

>>> rtl/core/blsl_cell.sv
// ----------------------------------------------------------------------------
// blsl_cell
// One list slot. Holds one word, shifts it to or from its neighbors, and
// reports its compare, ordering and read results to the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module blsl_cell #(
   parameter int DEPTH = blsl_pkg::DEPTH_DEF,
   parameter int IDX   = 0
) (
   input  wire                               clock,
   input  wire  blsl_pkg::cell_ctl_type      ctl,
   input  wire  [$clog2(DEPTH)-1:0]          pos,
   input  wire  [$clog2(DEPTH+1)-1:0]        count,
   input  wire  [$clog2(DEPTH)-1:0]          rd_idx,
   input  wire  [blsl_pkg::VALUE_W-1:0]      left_word,
   input  wire  [blsl_pkg::VALUE_W-1:0]      right_word,
   input  wire                               seen_in,
   output logic [blsl_pkg::VALUE_W-1:0]      word,
   output logic                              seen_out,
   output logic                              hit,
   output logic                              asc_ok,
   output logic [blsl_pkg::VALUE_W-1:0]      rd_word
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [IW-1:0] IDX_C  = IW'(IDX);
   localparam logic [CW-1:0] IDX_N  = CW'(IDX);
   localparam logic [CW-1:0] IDX_N1 = CW'(IDX + 1);

   logic [blsl_pkg::VALUE_W-1:0] word_ff;
   logic [blsl_pkg::VALUE_W-1:0] word_in;
   logic                         valid;
   logic                         match;

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         blsl_pkg::CELL_SHIFT_UP: begin
            if (IDX_C == pos) begin
               word_in = ctl.word;
            end else if (IDX_C > pos) begin
               word_in = left_word;
            end
         end
         blsl_pkg::CELL_SHIFT_DOWN: begin
            if (IDX_C >= pos) begin
               word_in = right_word;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_comb begin
      valid = IDX_N < count;
      if (ctl.cmp == blsl_pkg::CMP_EQUAL) begin
         match = valid && (word_ff == ctl.key);
      end else begin
         match = valid && !($signed(word_ff) < $signed(ctl.key));
      end
      // Only the first matching slot of the chain reports a hit.
      hit      = match && !seen_in;
      seen_out = seen_in || match;
      asc_ok   = !(IDX_N1 < count) || ($signed(word_ff) < $signed(right_word));
      rd_word  = (IDX_C == rd_idx) ? word_ff : '0;
      word     = word_ff;
   end

endmodule

`default_nettype wire

>>> rtl/core/bounded_sequence_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine
// Ordered list of up to DEPTH signed words held in a chain of slot cells,
// with insert, delete, search, ordered insert, reverse and indexed read.
// ----------------------------------------------------------------------------
// A request is registered, evaluated in the execute state, and its result
// registered in the output register; execute waits while that register holds
// an unaccepted result. Requests are taken only in the idle state; reverse
// makes count-1 slot moves in the cell chain, one per cycle, then posts its result.
// A new request is taken while a finished result waits in the output register.
// Reset clears the element count and the handshake state; slot contents are
// not cleared and are never read before being written.
`default_nettype none

module bounded_sequence_list_engine #(
   parameter int DEPTH = blsl_pkg::DEPTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // mode[3:0], value[35:4], position[41:36], zero fill above
   input  wire  [blsl_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // status[2:0], result_value[34:3], found_index[39:35], entry_count[45:40]
   output logic [blsl_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int XW = (CW > blsl_pkg::POS_W) ? CW : blsl_pkg::POS_W;
   localparam int VW = blsl_pkg::VALUE_W;

   blsl_pkg::seq_state_type  state_ff, state_in;
   logic [blsl_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [VW-1:0]            value_ff, value_in;
   logic [blsl_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            rev_k_ff, rev_k_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   blsl_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [VW-1:0]            rsp_value_ff, rsp_value_in;
   logic [blsl_pkg::FIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [blsl_pkg::ECNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Cell chain
   blsl_pkg::cell_ctl_type   cell_ctl;
   logic [IW-1:0]            cell_pos;
   logic [IW-1:0]            rd_idx;
   logic [VW-1:0]            cell_word [DEPTH];
   logic [VW-1:0]            cell_rd   [DEPTH];
   logic [DEPTH:0]           seen;
   logic [DEPTH-1:0]         hit;
   logic [DEPTH-1:0]         asc;

   // Chain summaries
   logic                     any_hit;
   logic [IW-1:0]            hit_idx;
   logic [VW-1:0]            rd_val;
   logic                     sorted;

   // Operation decode
   blsl_pkg::status_type     ex_status;
   blsl_pkg::cell_op_type    ex_op;
   logic [IW-1:0]            ex_pos;
   logic [VW-1:0]            ex_value;
   logic [IW-1:0]            ex_index;
   logic [CW-1:0]            ex_count;
   logic                     ex_reverse;

   logic                     req_fire;
   logic                     out_free;
   logic                     rev_step;
   logic                     load_rsp;
   logic                     full;
   logic                     empty;
   logic [IW-1:0]            last_idx;
   logic [XW-1:0]            count_x;
   logic [XW-1:0]            pos_x;

   assign seen[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [VW-1:0] left_w;
         logic [VW-1:0] right_w;
         if (g == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_mid
            assign left_w = cell_word[g-1];
         end
         if (g == DEPTH-1) begin : g_last
            assign right_w = cell_word[g];
         end else begin : g_inner
            assign right_w = cell_word[g+1];
         end
         blsl_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
         ) u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .pos        (cell_pos),
            .count      (count_ff),
            .rd_idx     (rd_idx),
            .left_word  (left_w),
            .right_word (right_w),
            .seen_in    (seen[g]),
            .word       (cell_word[g]),
            .seen_out   (seen[g+1]),
            .hit        (hit[g]),
            .asc_ok     (asc[g]),
            .rd_word    (cell_rd[g])
         );
      end
   endgenerate

   always_comb begin
      hit_idx = '0;
      rd_val  = '0;
      sorted  = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit[i]) begin
            hit_idx = hit_idx | IW'(i);
         end
         rd_val = rd_val | cell_rd[i];
         sorted = sorted & asc[i];
      end
      any_hit = seen[DEPTH];
   end

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == blsl_pkg::SEQ_IDLE);

   always_comb begin
      count_x  = XW'(count_ff);
      pos_x    = XW'(pos_ff);
      full     = (count_ff == CW'(DEPTH));
      empty    = (count_ff == '0);
      last_idx = IW'(count_ff - CW'(1));
      rev_step = (CW'(rev_k_ff) + CW'(1)) < count_ff;
   end

   // Read address of the chain; reverse and rear delete both read the last slot.
   always_comb begin
      unique case (mode_ff) inside
         blsl_pkg::MODE_DEL_FRONT:                        rd_idx = '0;
         blsl_pkg::MODE_DEL_AT, blsl_pkg::MODE_READ_AT:   rd_idx = IW'(pos_ff);
         default:                                         rd_idx = last_idx;
      endcase
   end

   always_comb begin
      ex_status  = blsl_pkg::STATUS_OK;
      ex_op      = blsl_pkg::CELL_HOLD;
      ex_pos     = '0;
      ex_value   = '0;
      ex_index   = '0;
      ex_count   = count_ff;
      ex_reverse = 1'b0;
      unique case (mode_ff) inside
         blsl_pkg::MODE_INS_FRONT, blsl_pkg::MODE_INS_REAR: begin
            if (full) begin
               ex_status = blsl_pkg::STATUS_FULL;
            end else begin
               ex_op    = blsl_pkg::CELL_SHIFT_UP;
               ex_pos   = (mode_ff == blsl_pkg::MODE_INS_FRONT) ? '0 : IW'(count_ff);
               ex_count = count_ff + CW'(1);
            end
         end
         blsl_pkg::MODE_INS_AT: begin
            if (pos_x > count_x) begin
               ex_status = blsl_pkg::STATUS_BAD_POS;
            end else if (full) begin
               ex_status = blsl_pkg::STATUS_FULL;
            end else begin
               ex_op    = blsl_pkg::CELL_SHIFT_UP;
               ex_pos   = IW'(pos_ff);
               ex_count = count_ff + CW'(1);
            end
         end
         blsl_pkg::MODE_DEL_FRONT, blsl_pkg::MODE_DEL_REAR: begin
            if (empty) begin
               ex_status = blsl_pkg::STATUS_EMPTY;
            end else begin
               ex_op    = blsl_pkg::CELL_SHIFT_DOWN;
               ex_pos   = rd_idx;
               ex_value = rd_val;
               ex_count = count_ff - CW'(1);
            end
         end
         blsl_pkg::MODE_DEL_AT: begin
            if (pos_x >= count_x) begin
               ex_status = blsl_pkg::STATUS_BAD_POS;
            end else begin
               ex_op    = blsl_pkg::CELL_SHIFT_DOWN;
               ex_pos   = rd_idx;
               ex_value = rd_val;
               ex_count = count_ff - CW'(1);
            end
         end
         blsl_pkg::MODE_DEL_KEY, blsl_pkg::MODE_SEARCH: begin
            if (!any_hit) begin
               ex_status = blsl_pkg::STATUS_NOT_FOUND;
            end else begin
               ex_value = value_ff;
               ex_index = hit_idx;
               if (mode_ff == blsl_pkg::MODE_DEL_KEY) begin
                  ex_op    = blsl_pkg::CELL_SHIFT_DOWN;
                  ex_pos   = hit_idx;
                  ex_count = count_ff - CW'(1);
               end
            end
         end
         blsl_pkg::MODE_INS_ORDERED: begin
            if (!sorted) begin
               ex_status = blsl_pkg::STATUS_NOT_SORTED;
            end else if (full) begin
               ex_status = blsl_pkg::STATUS_FULL;
            end else begin
               ex_op    = blsl_pkg::CELL_SHIFT_UP;
               ex_pos   = any_hit ? hit_idx : IW'(count_ff);
               ex_count = count_ff + CW'(1);
            end
         end
         blsl_pkg::MODE_REVERSE: begin
            if (empty) begin
               ex_status = blsl_pkg::STATUS_EMPTY;
            end else begin
               ex_reverse = 1'b1;
            end
         end
         blsl_pkg::MODE_READ_AT: begin
            if (pos_x >= count_x) begin
               ex_status = blsl_pkg::STATUS_BAD_POS;
            end else begin
               ex_value = rd_val;
            end
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         blsl_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               state_in = blsl_pkg::SEQ_EXEC;
            end
         end
         blsl_pkg::SEQ_EXEC: begin
            if (ex_reverse) begin
               state_in = blsl_pkg::SEQ_REVERSE;
            end else if (out_free) begin
               state_in = blsl_pkg::SEQ_IDLE;
            end
         end
         blsl_pkg::SEQ_REVERSE: begin
            if (!rev_step && out_free) begin
               state_in = blsl_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = blsl_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer. Reverse moves the rear word into slot k and
   // pushes slots k and up one place toward the rear, for k = 0 .. count-2.
   always_comb begin
      cell_ctl.op   = blsl_pkg::CELL_HOLD;
      cell_ctl.cmp  = (mode_ff == blsl_pkg::MODE_INS_ORDERED) ? blsl_pkg::CMP_NOT_LESS
                                                              : blsl_pkg::CMP_EQUAL;
      cell_ctl.word = value_ff;
      cell_ctl.key  = value_ff;
      cell_pos      = ex_pos;
      count_in      = count_ff;
      rev_k_in      = rev_k_ff;
      load_rsp      = 1'b0;
      rsp_status_in = ex_status;
      rsp_value_in  = ex_value;
      rsp_index_in  = blsl_pkg::FIDX_W'(ex_index);
      rsp_count_in  = blsl_pkg::ECNT_W'(ex_count);
      mode_in       = mode_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      unique case (state_ff)
         blsl_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               mode_in  = req_tdata[3:0];
               value_in = req_tdata[35:4];
               pos_in   = req_tdata[41:36];
            end
         end
         blsl_pkg::SEQ_EXEC: begin
            if (ex_reverse) begin
               rev_k_in = '0;
            end else if (out_free) begin
               load_rsp = 1'b1;
               cell_ctl.op = ex_op;
               count_in = ex_count;
            end
         end
         blsl_pkg::SEQ_REVERSE: begin
            rsp_status_in = blsl_pkg::STATUS_OK;
            rsp_value_in  = '0;
            rsp_index_in  = '0;
            rsp_count_in  = blsl_pkg::ECNT_W'(count_ff);
            if (rev_step) begin
               cell_ctl.op   = blsl_pkg::CELL_SHIFT_UP;
               cell_ctl.word = rd_val;
               cell_pos      = rev_k_ff;
               rev_k_in      = rev_k_ff + IW'(1);
            end else if (out_free) begin
               load_rsp = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blsl_pkg::SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      rev_k_ff <= rev_k_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_index_ff, rsp_value_ff, rsp_status_ff};

   // The element count never exceeds the number of slots.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above capacity");

   // During reverse the slot pointer stays inside the occupied part of the chain.
   a_rev_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == blsl_pkg::SEQ_REVERSE) |-> (CW'(rev_k_ff) < count_ff))
      else $error("reverse pointer outside list");

   // An operation that reports an error leaves the element count unchanged.
   a_err_no_change : assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (rsp_status_in != blsl_pkg::STATUS_OK)) |=>
         (count_ff == $past(count_ff)))
      else $error("count changed on an error result");

   // Nothing moves in the chain while no request is in progress.
   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == blsl_pkg::SEQ_IDLE) |-> (cell_ctl.op == blsl_pkg::CELL_HOLD))
      else $error("cell chain moved while idle");

endmodule

`default_nettype wire
